// ===== src/at_rx_line_value_extractor_macros.svh =====
// assertion macros for the received line value extractor
`ifndef AT_RX_LINE_VALUE_EXTRACTOR_MACROS_SVH
`define AT_RX_LINE_VALUE_EXTRACTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AT_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define AT_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/atrx_pkg.sv =====
// shared types, character codes and constants for the line value extractor
package atrx_pkg;

    localparam int MARK_LEN = 9;

    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // floor(2^32 / 100): quotient estimate is low by at most one
    localparam logic [25:0] RECIP100 = 26'd42949672;
    localparam logic [6:0]  DEC100   = 7'd100;

    typedef enum logic [2:0] {
        DLM_NONE,
        DLM_ONE_A,
        DLM_PAYLOAD,
        DLM_PAYLOAD_A,
        DLM_DONE
    } delim_t;

    typedef enum logic [1:0] {
        NUM_LEAD,
        NUM_SIGN,
        NUM_DIGITS,
        NUM_END
    } num_t;

    // handoff of a qualifying line from the parser
    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [31:0] mag;
    } mag_t;

    // split result ahead of the output register
    typedef struct packed {
        logic        valid;
        logic [31:0] value;
        logic [18:0] whole;
        logic [7:0]  hund;
        logic [7:0]  hum;
    } result_t;

    function automatic logic [7:0] mark_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h2B; // '+'
            4'd1:    c = 8'h54; // 'T'
            4'd2:    c = 8'h45; // 'E'
            4'd3:    c = 8'h53; // 'S'
            4'd4:    c = 8'h54; // 'T'
            4'd5:    c = 8'h3A; // ':'
            4'd6:    c = 8'h20; // ' '
            4'd7:    c = 8'h52; // 'R'
            4'd8:    c = 8'h58; // 'X'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/atrx_line_parser.sv =====
// per-byte line tracker: marker match, delimiter phases, number accumulate
module atrx_line_parser #(
    parameter int LINE_MAX    = 128,
    parameter int PAYLOAD_MAX = 19
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            ch_valid,
    input  logic [7:0]      ch,
    output atrx_pkg::mag_t  hand
);

    localparam int LW = $clog2(LINE_MAX + 1);
    localparam int PW = $clog2(PAYLOAD_MAX + 1);

    logic [3:0]       marker_pos_reg, marker_pos_next;
    logic             marker_seen_reg, marker_seen_next;
    atrx_pkg::delim_t delim_reg, delim_next;
    logic [PW-1:0]    payload_len_reg, payload_len_next;
    atrx_pkg::num_t   num_reg, num_next;
    logic             negative_reg, negative_next;
    logic [31:0]      accum_reg, accum_next;
    logic [LW-1:0]    line_len_reg, line_len_next;

    logic             hand_valid_reg, hand_valid_next;
    logic             hand_neg_reg;
    logic [31:0]      hand_mag_reg;

    logic             accept;
    logic             is_digit;
    logic             is_space;
    logic             is_a;
    logic [35:0]      grown;
    logic [35:0]      limit;
    logic [31:0]      acc_dig;
    logic             line_ok;

    assign accept   = ch_valid && adv;
    assign is_digit = (ch >= atrx_pkg::CHAR_ZERO) && (ch <= atrx_pkg::CHAR_NINE);
    assign is_space = (ch == atrx_pkg::CHAR_SPACE)
                   || ((ch >= atrx_pkg::CHAR_TAB) && (ch <= atrx_pkg::CHAR_CR));
    assign is_a     = (ch == atrx_pkg::CHAR_A);

    // accum * 10 + digit, clamped to the signed limit
    assign grown   = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1) + {32'b0, ch[3:0]};
    assign limit   = negative_reg ? 36'h080000000 : 36'h07FFFFFFF;
    assign acc_dig = (grown > limit) ? limit[31:0] : grown[31:0];

    always_comb
    begin
        marker_pos_next  = marker_pos_reg;
        marker_seen_next = marker_seen_reg;
        delim_next       = delim_reg;
        payload_len_next = payload_len_reg;
        num_next         = num_reg;
        negative_next    = negative_reg;
        accum_next       = accum_reg;
        line_len_next    = line_len_reg;
        if (accept)
        begin
            if (ch == atrx_pkg::NEWLINE)
            begin
                marker_pos_next  = '0;
                marker_seen_next = 1'b0;
                delim_next       = atrx_pkg::DLM_NONE;
                payload_len_next = '0;
                num_next         = atrx_pkg::NUM_LEAD;
                negative_next    = 1'b0;
                accum_next       = '0;
                line_len_next    = '0;
            end
            else
            begin
                if (line_len_reg < LW'(LINE_MAX))
                begin
                    line_len_next = line_len_reg + LW'(1);
                end
                if (!marker_seen_reg)
                begin
                    if ((marker_pos_reg < 4'(atrx_pkg::MARK_LEN))
                        && (ch == atrx_pkg::mark_char(marker_pos_reg)))
                    begin
                        marker_pos_next = marker_pos_reg + 4'd1;
                        if (marker_pos_reg == 4'(atrx_pkg::MARK_LEN - 1))
                        begin
                            marker_seen_next = 1'b1;
                        end
                    end
                    else
                    begin
                        marker_pos_next = (ch == atrx_pkg::mark_char(4'd0)) ? 4'd1 : 4'd0;
                    end
                end
                unique case (delim_reg)
                    atrx_pkg::DLM_NONE:
                    begin
                        if (is_a)
                        begin
                            delim_next = atrx_pkg::DLM_ONE_A;
                        end
                    end
                    atrx_pkg::DLM_ONE_A:
                    begin
                        delim_next = is_a ? atrx_pkg::DLM_PAYLOAD : atrx_pkg::DLM_NONE;
                    end
                    atrx_pkg::DLM_PAYLOAD:
                    begin
                        if (is_a)
                        begin
                            delim_next = atrx_pkg::DLM_PAYLOAD_A;
                        end
                        else if (payload_len_reg < PW'(PAYLOAD_MAX))
                        begin
                            payload_len_next = payload_len_reg + PW'(1);
                            unique case (num_reg)
                                atrx_pkg::NUM_LEAD:
                                begin
                                    priority if (is_space)
                                    begin
                                        num_next = atrx_pkg::NUM_LEAD;
                                    end
                                    else if ((ch == atrx_pkg::CHAR_PLUS)
                                             || (ch == atrx_pkg::CHAR_MINUS))
                                    begin
                                        negative_next = (ch == atrx_pkg::CHAR_MINUS);
                                        num_next      = atrx_pkg::NUM_SIGN;
                                    end
                                    else if (is_digit)
                                    begin
                                        accum_next = acc_dig;
                                        num_next   = atrx_pkg::NUM_DIGITS;
                                    end
                                    else
                                    begin
                                        num_next = atrx_pkg::NUM_END;
                                    end
                                end
                                atrx_pkg::NUM_SIGN,
                                atrx_pkg::NUM_DIGITS:
                                begin
                                    if (is_digit)
                                    begin
                                        accum_next = acc_dig;
                                        num_next   = atrx_pkg::NUM_DIGITS;
                                    end
                                    else
                                    begin
                                        num_next = atrx_pkg::NUM_END;
                                    end
                                end
                                default:
                                begin
                                    num_next = num_reg;
                                end
                            endcase
                        end
                    end
                    atrx_pkg::DLM_PAYLOAD_A:
                    begin
                        if (is_a)
                        begin
                            delim_next = atrx_pkg::DLM_DONE;
                        end
                        else
                        begin
                            // a lone 'A' ends the number, then this byte takes a slot too
                            delim_next = atrx_pkg::DLM_PAYLOAD;
                            if (payload_len_reg < PW'(PAYLOAD_MAX))
                            begin
                                num_next = atrx_pkg::NUM_END;
                                if ((payload_len_reg + PW'(1)) < PW'(PAYLOAD_MAX))
                                begin
                                    payload_len_next = payload_len_reg + PW'(1) + PW'(1);
                                end
                                else
                                begin
                                    payload_len_next = payload_len_reg + PW'(1);
                                end
                            end
                        end
                    end
                    default:
                    begin
                        delim_next = delim_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        line_ok = (line_len_reg < LW'(LINE_MAX)) && marker_seen_reg
               && (delim_reg == atrx_pkg::DLM_DONE) && (accum_reg != 32'd0);
        hand_valid_next = accept && (ch == atrx_pkg::NEWLINE) && line_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_pos_reg  <= '0;
            marker_seen_reg <= 1'b0;
            delim_reg       <= atrx_pkg::DLM_NONE;
            payload_len_reg <= '0;
            num_reg         <= atrx_pkg::NUM_LEAD;
            negative_reg    <= 1'b0;
            accum_reg       <= '0;
            line_len_reg    <= '0;
            hand_valid_reg  <= 1'b0;
        end
        else
        begin
            marker_pos_reg  <= marker_pos_next;
            marker_seen_reg <= marker_seen_next;
            delim_reg       <= delim_next;
            payload_len_reg <= payload_len_next;
            num_reg         <= num_next;
            negative_reg    <= negative_next;
            accum_reg       <= accum_next;
            line_len_reg    <= line_len_next;
            if (adv)
            begin
                hand_valid_reg <= hand_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hand_neg_reg <= negative_reg;
            hand_mag_reg <= accum_reg;
        end
    end

    assign hand.valid = hand_valid_reg;
    assign hand.neg   = hand_neg_reg;
    assign hand.mag   = hand_mag_reg;

endmodule

// ===== src/atrx_dec_split.sv =====
// pipelined split of the magnitude into /10000, /100 %100 and %100 parts
module atrx_dec_split (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  atrx_pkg::mag_t    hand,
    output atrx_pkg::result_t res
);

    // stage one: reciprocal product for /100
    logic        v1_reg;
    logic        neg1_reg;
    logic [31:0] mag1_reg;
    logic [57:0] prod1_reg;

    // stage two: corrected first quotient and humidity
    logic        v2_reg;
    logic        neg2_reg;
    logic [31:0] mag2_reg;
    logic [24:0] q1_reg;
    logic [6:0]  hum2_reg;

    // stage three: reciprocal product for the second /100
    logic        v3_reg;
    logic        neg3_reg;
    logic [31:0] mag3_reg;
    logic [24:0] q13_reg;
    logic [6:0]  hum3_reg;
    logic [50:0] prod2_reg;

    logic [25:0] qe1;
    logic [31:0] rem1;
    logic [24:0] q1_next;
    logic [6:0]  hum_next;
    logic [18:0] qe2;
    logic [24:0] rem2;
    logic [17:0] whole_mag;
    logic [6:0]  hund_mag;

    always_comb
    begin
        qe1  = prod1_reg[57:32];
        rem1 = mag1_reg - (32'(qe1) * 32'(atrx_pkg::DEC100));
        if (rem1 >= 32'(atrx_pkg::DEC100))
        begin
            q1_next  = 25'(qe1 + 26'd1);
            hum_next = 7'(rem1 - 32'(atrx_pkg::DEC100));
        end
        else
        begin
            q1_next  = 25'(qe1);
            hum_next = 7'(rem1);
        end
    end

    always_comb
    begin
        qe2  = prod2_reg[50:32];
        rem2 = q13_reg - (25'(qe2) * 25'(atrx_pkg::DEC100));
        if (rem2 >= 25'(atrx_pkg::DEC100))
        begin
            whole_mag = 18'(qe2 + 19'd1);
            hund_mag  = 7'(rem2 - 25'(atrx_pkg::DEC100));
        end
        else
        begin
            whole_mag = 18'(qe2);
            hund_mag  = 7'(rem2);
        end
    end

    // truncation toward zero: split the magnitude, then restore the sign
    always_comb
    begin
        res.valid = v3_reg;
        res.value = neg3_reg ? (32'd0 - mag3_reg) : mag3_reg;
        res.whole = neg3_reg ? (19'd0 - {1'b0, whole_mag}) : {1'b0, whole_mag};
        res.hund  = neg3_reg ? (8'd0 - {1'b0, hund_mag}) : {1'b0, hund_mag};
        res.hum   = neg3_reg ? (8'd0 - {1'b0, hum3_reg}) : {1'b0, hum3_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= hand.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg1_reg  <= hand.neg;
            mag1_reg  <= hand.mag;
            prod1_reg <= 58'(hand.mag) * 58'(atrx_pkg::RECIP100);
            neg2_reg  <= neg1_reg;
            mag2_reg  <= mag1_reg;
            q1_reg    <= q1_next;
            hum2_reg  <= hum_next;
            neg3_reg  <= neg2_reg;
            mag3_reg  <= mag2_reg;
            q13_reg   <= q1_reg;
            hum3_reg  <= hum2_reg;
            prod2_reg <= 51'(q1_reg) * 51'(atrx_pkg::RECIP100);
        end
    end

endmodule

// ===== src/at_rx_line_value_extractor.sv =====
// top level of the received line value extractor
// One received character is taken per transfer, one per cycle whenever the
// result register is empty or being drained. Each byte updates the line
// tracker in the cycle it is accepted (marker match, delimiter phase and a
// times-ten accumulate of the payload number). A newline that ends a
// qualifying line with a nonzero value yields one result transfer, passing
// in turn through the handoff register, the stages of the decimal split
// (two of them reciprocal-multiply stages) and the result register. A
// stalled result register holds the whole pipeline, and input ready drops
// with it.
`include "at_rx_line_value_extractor_macros.svh"

module at_rx_line_value_extractor #(
    parameter int LINE_MAX    = 128,
    parameter int PAYLOAD_MAX = 19
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [31:0] value, [50:32] temp_whole,
                                   // [58:51] temp_hundredths, [66:59] humidity_pct,
                                   // [71:67] zero
);

    logic              adv;
    atrx_pkg::mag_t    hand;
    atrx_pkg::result_t res;

    logic              out_valid_reg, out_valid_next;
    logic [71:0]       out_data_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    atrx_line_parser #(
        .LINE_MAX    (LINE_MAX),
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ch_valid (s_tvalid),
        .ch       (s_tdata),
        .hand     (hand)
    );

    atrx_dec_split u_split (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .hand  (hand),
        .res   (res)
    );

    assign out_valid_next = adv ? res.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {5'b0, res.hum, res.hund, res.whole, res.value};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `AT_ASSERT_IMP(a_value_nonzero, m_tvalid, m_tdata[31:0] != 32'd0, "zero value delivered")
    `AT_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken during stall")
    `AT_ASSERT_IMP(a_hum_sign, m_tvalid && !m_tdata[31], !m_tdata[66], "humidity sign mismatch")
    `AT_ASSERT_NXT(a_handoff_on_newline, s_tvalid && s_tready && (s_tdata != atrx_pkg::NEWLINE), !hand.valid, "handoff without newline")

endmodule

// ===== bench/tb_at_rx_line_value_extractor.sv =====
// testbench for the received line value extractor: directed lines, then random lines
`timescale 1ns / 100ps

module tb_at_rx_line_value_extractor;

    localparam int LINE_LIMIT    = 128;
    localparam int PAYLOAD_LIMIT = 19;
    localparam int MARKER_LEN    = 9;
    localparam logic [8*MARKER_LEN-1:0] MARKER_TEXT = "+TEST: RX";
    localparam logic [7:0] CHAR_VTAB = 8'h0B;
    localparam logic [7:0] CHAR_FF   = 8'h0C;
    localparam int ITEM_TARGET   = 400;
    localparam int DRAIN_CYCLES  = 10;
    localparam int LONG_HOLD     = 400;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_TYPED
    } check_t;

    typedef struct packed {
        logic [31:0] value;
        logic [18:0] whole;
        logic [7:0]  hund;
        logic [7:0]  hum;
    } reading_t;

    typedef struct {
        string      head;
        int         fill_n;
        logic [7:0] fill_c;
        string      tail;
        check_t     chk;
        reading_t   want;
    } line_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [31:0] value, [50:32] temp_whole, [58:51] temp_hundredths,
                            // [66:59] humidity_pct, [71:67] zero

    reading_t   pending_readings[$];
    line_row_t  line_rows[$];
    logic [7:0] line_bytes[$];
    int         bad_readings;
    int         readings_seen;
    int         bytes_sent;
    bit         quiet_line;

    // line tracker state
    logic [3:0]       mark_len_q;
    bit               mark_found;
    atrx_pkg::delim_t delim_st;
    int               pay_taken;
    atrx_pkg::num_t   num_st;
    bit               num_neg;
    logic [31:0]      num_mag;
    int               line_count;

    at_rx_line_value_extractor #(
        .LINE_MAX    (LINE_LIMIT),
        .PAYLOAD_MAX (PAYLOAD_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("at_rx_line_value_extractor: mismatch");
        $finish;
    end

    function automatic logic [7:0] marker_char(input int idx);
        return MARKER_TEXT[8*(MARKER_LEN-1-idx) +: 8];
    endfunction

    function automatic void clear_line_state();
        mark_len_q = '0;
        mark_found = 1'b0;
        delim_st   = atrx_pkg::DLM_NONE;
        pay_taken  = 0;
        num_st     = atrx_pkg::NUM_LEAD;
        num_neg    = 1'b0;
        num_mag    = '0;
        line_count = 0;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= atrx_pkg::CHAR_ZERO && c <= atrx_pkg::CHAR_NINE;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        longint unsigned lim;
        longint unsigned nxt;
        lim = num_neg ? 64'd2147483648 : 64'd2147483647;
        nxt = 64'(num_mag) * 64'd10 + 64'(c - atrx_pkg::CHAR_ZERO);
        if (nxt > lim)
            nxt = lim;
        num_mag = nxt[31:0];
    endfunction

    function automatic void feed_payload_char(input logic [7:0] c);
        if (pay_taken < PAYLOAD_LIMIT)
        begin
            pay_taken++;
            case (num_st)
                atrx_pkg::NUM_LEAD:
                begin
                    if (c == atrx_pkg::CHAR_SPACE
                        || (c >= atrx_pkg::CHAR_TAB && c <= atrx_pkg::CHAR_CR))
                        num_st = atrx_pkg::NUM_LEAD;
                    else if (c == atrx_pkg::CHAR_PLUS || c == atrx_pkg::CHAR_MINUS)
                    begin
                        num_neg = (c == atrx_pkg::CHAR_MINUS);
                        num_st  = atrx_pkg::NUM_SIGN;
                    end
                    else if (is_digit(c))
                    begin
                        take_digit(c);
                        num_st = atrx_pkg::NUM_DIGITS;
                    end
                    else
                        num_st = atrx_pkg::NUM_END;
                end
                atrx_pkg::NUM_SIGN, atrx_pkg::NUM_DIGITS:
                begin
                    if (is_digit(c))
                    begin
                        take_digit(c);
                        num_st = atrx_pkg::NUM_DIGITS;
                    end
                    else
                        num_st = atrx_pkg::NUM_END;
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void step_marker(input logic [7:0] c);
        if (!mark_found)
        begin
            if (c == marker_char(int'(mark_len_q)))
            begin
                mark_len_q++;
                if (mark_len_q == MARKER_LEN)
                    mark_found = 1'b1;
            end
            else
                mark_len_q = (c == marker_char(0)) ? 4'd1 : 4'd0;
        end
    endfunction

    function automatic void step_delim(input logic [7:0] c);
        case (delim_st)
            atrx_pkg::DLM_NONE:
                if (c == atrx_pkg::CHAR_A)
                    delim_st = atrx_pkg::DLM_ONE_A;
            atrx_pkg::DLM_ONE_A:
                delim_st = (c == atrx_pkg::CHAR_A) ? atrx_pkg::DLM_PAYLOAD : atrx_pkg::DLM_NONE;
            atrx_pkg::DLM_PAYLOAD:
                if (c == atrx_pkg::CHAR_A)
                    delim_st = atrx_pkg::DLM_PAYLOAD_A;
                else
                    feed_payload_char(c);
            atrx_pkg::DLM_PAYLOAD_A:
                if (c == atrx_pkg::CHAR_A)
                    delim_st = atrx_pkg::DLM_DONE;
                else
                begin
                    // a lone A was payload after all
                    feed_payload_char(atrx_pkg::CHAR_A);
                    feed_payload_char(c);
                    delim_st = atrx_pkg::DLM_PAYLOAD;
                end
            default: ;
        endcase
    endfunction

    function automatic reading_t split_reading(input longint v);
        reading_t r;
        longint   w;
        longint   h;
        longint   u;
        w = v / 10000;
        h = (v / 100) % 100;
        u = v % 100;
        r.value = v[31:0];
        r.whole = w[18:0];
        r.hund  = h[7:0];
        r.hum   = u[7:0];
        return r;
    endfunction

    function automatic reading_t typed_reading(input longint v, input longint w,
                                               input longint h, input longint u);
        reading_t r;
        r.value = v[31:0];
        r.whole = w[18:0];
        r.hund  = h[7:0];
        r.hum   = u[7:0];
        return r;
    endfunction

    // one byte into the line tracker; a qualifying newline yields a reading
    function automatic void line_tracker_step(input logic [7:0] c, output bit got,
                                              output reading_t r);
        longint v;
        got = 1'b0;
        r   = '0;
        if (c != atrx_pkg::NEWLINE)
        begin
            if (line_count < LINE_LIMIT)
                line_count++;
            step_marker(c);
            step_delim(c);
        end
        else
        begin
            if (line_count < LINE_LIMIT && mark_found && delim_st == atrx_pkg::DLM_DONE)
            begin
                v = longint'({32'b0, num_mag});
                if (num_neg)
                    v = -v;
                if (v != 0)
                begin
                    got = 1'b1;
                    r   = split_reading(v);
                end
            end
            clear_line_state();
        end
    endfunction

    function automatic void add_row(input string head, input int fill_n,
                                    input logic [7:0] fill_c, input string tail,
                                    input check_t chk, input reading_t want);
        line_row_t row;
        row.head   = head;
        row.fill_n = fill_n;
        row.fill_c = fill_c;
        row.tail   = tail;
        row.chk    = chk;
        row.want   = want;
        line_rows.push_back(row);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endfunction

    function automatic void push_noise(input int n, input bit allow_a);
        logic [7:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == atrx_pkg::NEWLINE || (!allow_a && c == atrx_pkg::CHAR_A))
                c = c ^ 8'h80;
            line_bytes.push_back(c);
        end
    endfunction

    function automatic void push_marker(input bit corrupt);
        int         bad_at;
        logic [7:0] c;
        bad_at = corrupt ? $urandom_range(0, MARKER_LEN - 1) : MARKER_LEN;
        for (int i = 0; i < MARKER_LEN; i++)
        begin
            c = marker_char(i);
            if (i == bad_at)
                c = 8'h80 | 8'($urandom_range(0, 127));
            line_bytes.push_back(c);
        end
    endfunction

    function automatic void push_payload();
        int r;
        int ws_n;
        int dig_n;
        r = $urandom_range(0, 9);
        ws_n = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(4, 20);
        repeat (ws_n)
        begin
            case ($urandom_range(0, 4))
                0:       line_bytes.push_back(atrx_pkg::CHAR_SPACE);
                1:       line_bytes.push_back(atrx_pkg::CHAR_TAB);
                2:       line_bytes.push_back(CHAR_VTAB);
                3:       line_bytes.push_back(CHAR_FF);
                default: line_bytes.push_back(atrx_pkg::CHAR_CR);
            endcase
        end
        r = $urandom_range(0, 2);
        if (r == 0)
            line_bytes.push_back(atrx_pkg::CHAR_PLUS);
        else if (r == 1)
            line_bytes.push_back(atrx_pkg::CHAR_MINUS);
        r = $urandom_range(0, 19);
        dig_n = (r == 0) ? 0 : (r < 15) ? $urandom_range(1, 6) :
                (r < 19) ? $urandom_range(7, 10) : $urandom_range(11, 16);
        repeat (dig_n)
            line_bytes.push_back(atrx_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            line_bytes.push_back(atrx_pkg::CHAR_A);
            line_bytes.push_back(atrx_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (r == 1)
            push_noise(1, 1'b0);
    endfunction

    function automatic void make_random_line();
        int  shape;
        int  target;
        bit  mark_late;
        bit  mark_bad;
        line_bytes.delete();
        shape     = $urandom_range(0, 99);
        mark_late = ($urandom_range(0, 3) == 0);
        mark_bad  = (shape >= 70 && shape < 80);
        if (shape >= 93)
            push_noise($urandom_range(0, 40), 1'b1);
        else
        begin
            if (!mark_late)
            begin
                push_noise($urandom_range(0, 3), 1'b0);
                if (!mark_bad || $urandom_range(0, 1))
                    push_marker(mark_bad);
            end
            push_noise($urandom_range(0, 3), 1'b0);
            line_bytes.push_back(atrx_pkg::CHAR_A);
            line_bytes.push_back(atrx_pkg::CHAR_A);
            push_payload();
            if (shape >= 80 && shape < 88)
            begin
                // closing delimiter broken or missing
                if ($urandom_range(0, 1))
                    line_bytes.push_back(atrx_pkg::CHAR_A);
            end
            else
            begin
                line_bytes.push_back(atrx_pkg::CHAR_A);
                line_bytes.push_back(atrx_pkg::CHAR_A);
            end
            push_noise($urandom_range(0, 3), 1'b0);
            if (mark_late && (!mark_bad || $urandom_range(0, 1)))
                push_marker(mark_bad);
            if (shape >= 88)
            begin
                // lines around the length limit
                target = $urandom_range(LINE_LIMIT - 3, LINE_LIMIT + 2);
                if (target > line_bytes.size())
                    push_noise(target - line_bytes.size(), 1'b0);
            end
        end
        line_bytes.push_back(atrx_pkg::NEWLINE);
    endfunction

    task automatic send_byte(input logic [7:0] b, output bit got, output reading_t r);
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        line_tracker_step(b, got, r);
    endtask

    task automatic idle_gap();
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet_line || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else if (pick < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_line(input check_t chk, input reading_t want);
        bit       got;
        reading_t r;
        quiet_line = ($urandom_range(0, 3) == 0);
        foreach (line_bytes[i])
        begin
            send_byte(line_bytes[i], got, r);
            if (chk == CHK_MODEL && got)
                pending_readings.push_back(r);
            if (chk == CHK_TYPED && line_bytes[i] == atrx_pkg::NEWLINE)
                pending_readings.push_back(want);
            idle_gap();
        end
    endtask

    task automatic hold_sender_until_drained();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void build_rows();
        add_row("+TEST: RX AA1AA", 0, 8'h00, "", CHK_TYPED, typed_reading(1, 0, 0, 1));
        add_row("+TEST: RX AA2147483647AA", 0, 8'h00, "", CHK_TYPED,
                typed_reading(2147483647, 214748, 36, 47));
        add_row("+TEST: RX AA-2147483648AA", 0, 8'h00, "", CHK_TYPED,
                typed_reading(-2147483648, -214748, -36, -48));
        // magnitude saturates at both limits
        add_row("+TEST: RX AA99999999999AA", 0, 8'h00, "", CHK_TYPED,
                typed_reading(2147483647, 214748, 36, 47));
        add_row("+TEST: RX AA-99999999999AA", 0, 8'h00, "", CHK_TYPED,
                typed_reading(-2147483648, -214748, -36, -48));
        add_row("AA55AA", 0, 8'h00, "", CHK_NONE, '0);
        add_row("+TEST: RX AA55A", 0, 8'h00, "", CHK_NONE, '0);
        add_row("+TEST: RX AA0AA", 0, 8'h00, "", CHK_NONE, '0);
        add_row("+TEST: RX AAAA", 0, 8'h00, "", CHK_NONE, '0);
        add_row("", 0, 8'h00, "", CHK_NONE, '0);
        // one byte short of the line limit, then exactly at it
        add_row("+TEST: RX AA7AA", LINE_LIMIT - 16, 8'h78, "", CHK_TYPED,
                typed_reading(7, 0, 0, 7));
        add_row("+TEST: RX AA7AA", LINE_LIMIT - 15, 8'h78, "", CHK_NONE, '0);
        add_row("+TEST: RX AA", 3, atrx_pkg::CHAR_TAB, "+1234AA", CHK_MODEL, '0);
        add_row("+TEST: RX AA", 2, atrx_pkg::CHAR_CR, "-12x34AA", CHK_MODEL, '0);
        add_row("+TEST: RX AA1A2AA", 0, 8'h00, "", CHK_MODEL, '0);
        add_row("AAA5AA+TEST: RX", 0, 8'h00, "", CHK_MODEL, '0);
        // payload cut after its first characters
        add_row("++TEST: RX zAA", PAYLOAD_LIMIT - 2, atrx_pkg::CHAR_SPACE, "123AA",
                CHK_MODEL, '0);
        add_row("+TEST: RX AA", 0, 8'h00, "1234567890123456789012AA", CHK_MODEL, '0);
        add_row("+TEST: RX AA-", 1, 8'h00, "9AA", CHK_MODEL, '0);
        add_row("+TEST: RX AA987654AA", 2, 8'hFF, "AA31AA", CHK_MODEL, '0);
        add_row("+TEST: RXAA+-5AA", 0, 8'h00, "", CHK_MODEL, '0);
        add_row("+TEST: R+TEST: RX AA-1AA", 0, 8'h00, "", CHK_MODEL, '0);
        add_row("AA-1AA +TEST: RX", 0, 8'h00, "", CHK_MODEL, '0);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            bad_readings++;
        end
    endfunction

    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            readings_seen++;
            if (pending_readings.size() == 0)
            begin
                $display("%0t: reading expected none actual %h", $time, m_tdata);
                bad_readings++;
            end
            else
            begin
                want = pending_readings.pop_front();
                check_field("value", want.value, m_tdata[31:0]);
                check_field("temp_whole", 32'(want.whole), 32'(m_tdata[50:32]));
                check_field("temp_hundredths", 32'(want.hund), 32'(m_tdata[58:51]));
                check_field("humidity_pct", 32'(want.hum), 32'(m_tdata[66:59]));
                check_field("pad", 32'd0, 32'(m_tdata[71:67]));
            end
        end
    end

    initial
    begin : result_sink
        int  pick;
        int  n;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && readings_seen >= 4)
            begin
                // long stall so the block backs up into its input
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 20);
            end
            else if (pick < 90)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 4);
            end
            else
            begin
                m_tready <= 1'b0;
                n = $urandom_range(10, 40);
            end
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin : byte_source
        int random_start;
        int lines_sent;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        bad_readings  = 0;
        readings_seen = 0;
        bytes_sent    = 0;
        quiet_line    = 1'b0;
        lines_sent    = 0;
        clear_line_state();
        build_rows();
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        foreach (line_rows[i])
        begin
            line_bytes.delete();
            push_text(line_rows[i].head);
            repeat (line_rows[i].fill_n)
                line_bytes.push_back(line_rows[i].fill_c);
            push_text(line_rows[i].tail);
            line_bytes.push_back(atrx_pkg::NEWLINE);
            send_line(line_rows[i].chk, line_rows[i].want);
        end
        hold_sender_until_drained();

        random_start = bytes_sent;
        while (bytes_sent - random_start < ITEM_TARGET)
        begin
            make_random_line();
            send_line(CHK_MODEL, '0);
            lines_sent++;
            if (lines_sent == 6)
                hold_sender_until_drained();
        end
        hold_sender_until_drained();

        if (bad_readings == 0)
            $display("at_rx_line_value_extractor: match");
        else
            $display("at_rx_line_value_extractor: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/atrx_pkg.sv
src/atrx_line_parser.sv
src/atrx_dec_split.sv
src/at_rx_line_value_extractor.sv
bench/tb_at_rx_line_value_extractor.sv
